// ----- rtl/npcm_pkg.sv -----
package npcm_pkg;

    localparam int PALETTE_SIZE = 64;
    localparam int IDX_W        = $clog2(PALETTE_SIZE);
    localparam int CNT_W        = 7;
    localparam int COLOR_W      = 24;
    localparam int CHAN_W       = 8;
    localparam int ERR_W        = 18;
    localparam int SUM_W        = 48;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CNT_W-1:0]   RESET_ENTRIES   = 7'd64;
    localparam logic [COLOR_W-1:0] RESET_KEY_COLOR = 24'hFF00FF;
    localparam logic               RESET_KEY_EN    = 1'b1;
    localparam logic [SUM_W-1:0]   SUM_MAX         = {SUM_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENTRIES_IN_USE = 2'd0,
        CFG_KEY_COLOR      = 2'd1,
        CFG_KEY_ENABLE     = 2'd2
    } cfg_index_t;

    typedef enum logic {
        CMD_PALETTE_WRITE = 1'b0,
        CMD_PIXEL         = 1'b1
    } cmd_t;

    typedef struct packed {
        logic              cmd;
        logic [5:0]        entry_index;
        logic [CHAN_W-1:0] pixel_red;
        logic [CHAN_W-1:0] pixel_green;
        logic [CHAN_W-1:0] pixel_blue;
        logic              last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [5:0]        color_index;
        logic              skipped;
        logic [ERR_W-1:0]  pixel_error;
        logic [SUM_W-1:0]  total_error;
        logic              frame_end;
    } out_item_t;

    typedef struct packed {
        logic               valid;
        logic               is_pixel;
        logic [IDX_W-1:0]   entry_index;
        logic [COLOR_W-1:0] pix;
        logic               last;
        logic               skip;
        logic [COLOR_W-1:0] best_color;
        logic [IDX_W-1:0]   best_index;
        logic [ERR_W-1:0]   best_err;
    } chain_t;

    function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d * d;
    endfunction

endpackage

// ----- rtl/nearest_palette_color_mapper_unit.sv -----
// Maps a stream of RGB pixels to the nearest colour of a palette of up to 64 entries held in a
// row of identical cells, one entry per cell. Every item (palette write or pixel) enters the
// row and moves one cell per cycle while the output is not stalled; each cell in use compares
// the pixel against its own entry and keeps the better candidate, lower index winning ties, so
// palette writes and pixels stay in order. One item is accepted per clock unless the output
// stalls, and a result passes through the cell row and then the output register that also
// keeps the saturating error sum. Palette writes give no result. A pixel equal to the key
// colour, with keying enabled, passes through with skipped set. Configuration writes are
// always ready and must be made while no items are in flight.
module nearest_palette_color_mapper_unit
    import npcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COLOR_W-1:0]   cfg_data
);

    logic [CNT_W-1:0]   entries_reg;
    logic [CNT_W-1:0]   entries_next;
    logic [COLOR_W-1:0] key_color_reg;
    logic [COLOR_W-1:0] key_color_next;
    logic               key_en_reg;
    logic               key_en_next;
    logic               advance;
    chain_t             head;
    chain_t             link [PALETTE_SIZE+1];
    logic [COLOR_W-1:0] in_pix;

    assign cfg_ready = 1'b1;
    assign advance   = !(out_valid && out_stall);
    assign in_stall  = !advance;

    always_comb
    begin
        entries_next   = entries_reg;
        key_color_next = key_color_reg;
        key_en_next    = key_en_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ENTRIES_IN_USE: entries_next   = cfg_data[CNT_W-1:0];
                CFG_KEY_COLOR:      key_color_next = cfg_data;
                CFG_KEY_ENABLE:     key_en_next    = cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= RESET_ENTRIES;
            key_color_reg <= RESET_KEY_COLOR;
            key_en_reg    <= RESET_KEY_EN;
        end
        else
        begin
            entries_reg   <= entries_next;
            key_color_reg <= key_color_next;
            key_en_reg    <= key_en_next;
        end
    end

    always_comb
    begin
        in_pix           = {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
        head             = '0;
        head.valid       = in_valid && advance;
        head.is_pixel    = (in_data.cmd == CMD_PIXEL);
        head.entry_index = IDX_W'(in_data.entry_index);
        head.pix         = in_pix;
        head.last        = in_data.last_pixel;
        head.skip        = key_en_reg && (in_pix == key_color_reg);
    end

    assign link[0] = head;

    for (genvar g = 0; g < PALETTE_SIZE; g++)
    begin : g_cell
        npcm_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .advance        (advance),
            .cell_id        (IDX_W'(g)),
            .entries_in_use (entries_reg),
            .chain_in       (link[g]),
            .chain_out      (link[g+1])
        );
    end

    npcm_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .chain_in  (link[PALETTE_SIZE]),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// ----- rtl/npcm_cell.sv -----
module npcm_cell
    import npcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [IDX_W-1:0] cell_id,
    input  logic [CNT_W-1:0] entries_in_use,
    input  chain_t           chain_in,
    output chain_t           chain_out
);

    logic [COLOR_W-1:0] entry_reg;
    logic [COLOR_W-1:0] entry_next;
    chain_t             stage_reg;
    chain_t             stage_next;
    logic [ERR_W-1:0]   sq_sum;
    logic               active;
    logic               take;

    always_comb
    begin
        sq_sum = ERR_W'(sq_diff(chain_in.pix[23:16], entry_reg[23:16]))
               + ERR_W'(sq_diff(chain_in.pix[15:8], entry_reg[15:8]))
               + ERR_W'(sq_diff(chain_in.pix[7:0], entry_reg[7:0]));
        active = (cell_id == '0) || ({1'b0, cell_id} < entries_in_use);
        take = chain_in.valid && chain_in.is_pixel && !chain_in.skip && active
            && ((cell_id == '0) || (sq_sum < chain_in.best_err));
    end

    always_comb
    begin
        stage_next = chain_in;
        if (take)
        begin
            stage_next.best_color = entry_reg;
            stage_next.best_index = cell_id;
            stage_next.best_err   = sq_sum;
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (chain_in.valid && !chain_in.is_pixel && (chain_in.entry_index == cell_id))
        begin
            entry_next = chain_in.pix;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign chain_out = stage_reg;

endmodule

// ----- rtl/npcm_accum.sv -----
module npcm_accum
    import npcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  chain_t    chain_in,
    output logic      out_valid,
    output out_item_t out_data
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic             valid_reg;
    logic             valid_next;
    out_item_t        data_reg;
    out_item_t        data_next;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;
    logic             is_result;

    always_comb
    begin
        is_result = chain_in.valid && chain_in.is_pixel;
        sum_wide  = {1'b0, sum_reg} + {{(SUM_W+1-ERR_W){1'b0}}, chain_in.best_err};
        sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    always_comb
    begin
        valid_next = is_result;
        sum_next   = sum_reg;
        if (is_result)
        begin
            sum_next = chain_in.last ? '0 : sum_sat;
        end
        data_next.out_red     = chain_in.skip ? chain_in.pix[23:16] : chain_in.best_color[23:16];
        data_next.out_green   = chain_in.skip ? chain_in.pix[15:8] : chain_in.best_color[15:8];
        data_next.out_blue    = chain_in.skip ? chain_in.pix[7:0] : chain_in.best_color[7:0];
        data_next.color_index = 6'(chain_in.best_index);
        data_next.skipped     = chain_in.skip;
        data_next.pixel_error = chain_in.best_err;
        data_next.total_error = sum_sat;
        data_next.frame_end   = chain_in.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_result)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/npcm_checker.sv -----
module npcm_checker
    import npcm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall does not follow output stall");

    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.skipped |-> out_data.color_index == '0
            && out_data.pixel_error == '0)
        else $error("skipped pixel carries index or error");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.total_error >= SUM_W'(out_data.pixel_error))
        else $error("running sum below pixel error");

endmodule

bind nearest_palette_color_mapper_unit npcm_checker u_npcm_checker (.*);

// ----- tb/palette_map_checker.sv -----
module palette_map_checker
    import npcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_item_t          out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  cfg_index_t         cfg_index,
    input  logic [COLOR_W-1:0] cfg_data,
    output int                 mismatch_count,
    output int                 pixels_due
);

    logic [COLOR_W-1:0] colors [PALETTE_SIZE];
    logic [SUM_W-1:0]   running_sum;
    logic [CNT_W-1:0]   search_count;
    logic [COLOR_W-1:0] key;
    logic               key_on;
    out_item_t          mapped_q [$];

    out_item_t          want;
    logic [COLOR_W-1:0] px;
    logic [SUM_W:0]     wide;
    int                 n;
    int                 best;
    int                 e;
    int                 dr;
    int                 dg;
    int                 db;

    initial
    begin
        mismatch_count = 0;
        pixels_due     = 0;
    end

    task automatic check_field(input string label, input logic [SUM_W-1:0] exp_v,
                               input logic [SUM_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, actual %0h", label, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum  = '0;
            search_count = RESET_ENTRIES;
            key          = RESET_KEY_COLOR;
            key_on       = RESET_KEY_EN;
            mapped_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ENTRIES_IN_USE: search_count = cfg_data[CNT_W-1:0];
                    CFG_KEY_COLOR:      key = cfg_data;
                    CFG_KEY_ENABLE:     key_on = cfg_data[0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                px = {in_data.pixel_red, in_data.pixel_green, in_data.pixel_blue};
                if (in_data.cmd == CMD_PALETTE_WRITE)
                begin
                    if (int'(in_data.entry_index) < PALETTE_SIZE)
                        colors[in_data.entry_index] = px;
                end
                else
                begin
                    want = '0;
                    want.frame_end = in_data.last_pixel;
                    if (key_on && px == key)
                    begin
                        want.skipped = 1'b1;
                        {want.out_red, want.out_green, want.out_blue} = px;
                    end
                    else
                    begin
                        n = int'(search_count);
                        if (n == 0)
                            n = 1;
                        if (n > PALETTE_SIZE)
                            n = PALETTE_SIZE;
                        if (n > (1 << $bits(in_data.entry_index)))
                            n = 1 << $bits(in_data.entry_index);
                        best = 0;
                        for (int i = 0; i < n; i++)
                        begin
                            dr = int'(px[23:16]) - int'(colors[i][23:16]);
                            dg = int'(px[15:8])  - int'(colors[i][15:8]);
                            db = int'(px[7:0])   - int'(colors[i][7:0]);
                            e  = dr * dr + dg * dg + db * db;
                            if (i == 0 || e < best)
                            begin
                                best = e;
                                want.color_index = i[5:0];
                            end
                        end
                        want.pixel_error = best[ERR_W-1:0];
                        {want.out_red, want.out_green, want.out_blue} =
                            colors[want.color_index];
                    end
                    wide = {1'b0, running_sum} + (SUM_W+1)'(want.pixel_error);
                    want.total_error = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
                    running_sum = want.frame_end ? '0 : want.total_error;
                    mapped_q = {mapped_q, want};
                end
            end

            if (out_valid && !out_stall)
            begin
                if (mapped_q.size() == 0)
                begin
                    $error("result transfer with no pixel outstanding");
                    mismatch_count++;
                end
                else
                begin
                    want = mapped_q.pop_front();
                    check_field("out_red", SUM_W'(want.out_red),
                                SUM_W'(out_data.out_red));
                    check_field("out_green", SUM_W'(want.out_green),
                                SUM_W'(out_data.out_green));
                    check_field("out_blue", SUM_W'(want.out_blue),
                                SUM_W'(out_data.out_blue));
                    check_field("color_index", SUM_W'(want.color_index),
                                SUM_W'(out_data.color_index));
                    check_field("skipped", SUM_W'(want.skipped),
                                SUM_W'(out_data.skipped));
                    check_field("pixel_error", SUM_W'(want.pixel_error),
                                SUM_W'(out_data.pixel_error));
                    check_field("total_error", want.total_error, out_data.total_error);
                    check_field("frame_end", SUM_W'(want.frame_end),
                                SUM_W'(out_data.frame_end));
                end
            end
        end
        pixels_due = mapped_q.size();
    end

endmodule

// ----- tb/nearest_palette_color_mapper_unit_test.sv -----
module nearest_palette_color_mapper_unit_test;
    import npcm_pkg::*;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_item_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_item_t          out_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index = CFG_ENTRIES_IN_USE;
    logic [COLOR_W-1:0] cfg_data  = '0;

    int                 mismatch_count;
    int                 pixels_due;

    bit                 send_gaps = 1'b1;
    bit                 recv_gaps = 1'b1;
    int                 hold_left = 0;
    logic [COLOR_W-1:0] swatches [16];
    logic [COLOR_W-1:0] key_now   = RESET_KEY_COLOR;

    nearest_palette_color_mapper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    palette_map_checker map_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_data       (out_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .pixels_due     (pixels_due)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left--;
        else if (recv_gaps && $urandom_range(0, 5) == 0)
            hold_left = $urandom_range(1, 12);
        out_stall <= (hold_left > 0);
    end

    initial
    begin
        #3200000;
        $display("tb: failure");
        $finish;
    end

    function automatic in_item_t make_item(input cmd_t c, input logic [5:0] slot,
                                           input logic [COLOR_W-1:0] rgb, input logic last);
        in_item_t item;
        item.cmd         = c;
        item.entry_index = slot;
        item.pixel_red   = rgb[23:16];
        item.pixel_green = rgb[15:8];
        item.pixel_blue  = rgb[7:0];
        item.last_pixel  = last;
        return item;
    endfunction

    task automatic push_item(input in_item_t item);
        int gap;
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [COLOR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // hold the sender until every pixel is out, then let trailing palette writes clear the row
    task automatic settle();
        in_valid <= 1'b0;
        do @(negedge clk); while (pixels_due != 0);
        repeat (PALETTE_SIZE + 16) @(negedge clk);
    endtask

    initial
    begin
        in_item_t           item;
        logic [COLOR_W-1:0] rgb;
        logic [CNT_W-1:0]   n;
        logic [COLOR_W-1:0] key;
        logic               en;
        int                 pick;

        swatches[0] = RESET_KEY_COLOR;
        for (int i = 1; i < 16; i++)
            swatches[i] = COLOR_W'($urandom);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < PALETTE_SIZE; k++)
        begin
            rgb = $urandom_range(0, 1) ? swatches[$urandom_range(0, 15)] : COLOR_W'($urandom);
            if (k == 0)
                rgb = 24'h000000;
            if (k == 10 || k == 20)
                rgb = 24'h123456;
            if (k == PALETTE_SIZE - 1)
                rgb = 24'hFFFFFF;
            push_item(make_item(CMD_PALETTE_WRITE, 6'(k), rgb, k == PALETTE_SIZE - 1));
        end
        push_item(make_item(CMD_PIXEL, 6'h3F, 24'hFFFFFF, 1'b0));
        push_item(make_item(CMD_PIXEL, 6'h00, 24'h000000, 1'b0));
        push_item(make_item(CMD_PIXEL, 6'h15, RESET_KEY_COLOR, 1'b0));
        push_item(make_item(CMD_PIXEL, 6'h2A, 24'h123456, 1'b0));
        push_item(make_item(CMD_PIXEL, 6'h00, 24'h123457, 1'b0));
        push_item(make_item(CMD_PIXEL, 6'h00, 24'hFF0000, 1'b0));
        push_item(make_item(CMD_PIXEL, 6'h00, 24'h00FF00, 1'b0));
        push_item(make_item(CMD_PIXEL, 6'h00, 24'h0000FF, 1'b0));
        push_item(make_item(CMD_PALETTE_WRITE, 6'h3F, 24'hFFFFFF, 1'b1));
        push_item(make_item(CMD_PIXEL, 6'h00, 24'h808080, 1'b1));
        push_item(make_item(CMD_PIXEL, 6'h00, 24'h7F7F7F, 1'b0));
        push_item(make_item(CMD_PIXEL, 6'h00, 24'h00FFFF, 1'b1));
        settle();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: begin n = 7'd0;   key = RESET_KEY_COLOR;             en = 1'b1; end
                1: begin n = 7'd1;   key = 24'h000000;                  en = 1'b1; end
                2: begin n = 7'd127; key = COLOR_W'($urandom);          en = 1'b0; end
                3: begin n = 7'd64;  key = 24'hFFFFFF;                  en = 1'b1; end
                4: begin n = 7'd100; key = swatches[$urandom_range(1, 15)]; en = 1'b1; end
                5: begin n = CNT_W'($urandom_range(2, 63)); key = COLOR_W'($urandom); en = 1'b1; end
                6: begin n = CNT_W'($urandom_range(1, 64)); key = RESET_KEY_COLOR; en = 1'b0; end
                default: begin n = 7'd64; key = RESET_KEY_COLOR; en = 1'b1; end
            endcase
            write_reg(CFG_KEY_COLOR, key);
            write_reg(CFG_ENTRIES_IN_USE, COLOR_W'(n));
            write_reg(CFG_KEY_ENABLE, COLOR_W'(en));
            key_now   = key;
            send_gaps = (phase != 7);
            recv_gaps = (phase != 7);

            for (int k = 0; k < 75; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                    rgb = key_now;
                else if (pick < 45)
                    rgb = swatches[$urandom_range(0, 15)];
                else if (pick < 60)
                    rgb = {$urandom_range(0, 1) ? 8'hFF : 8'h00,
                           $urandom_range(0, 1) ? 8'hFF : 8'h00,
                           $urandom_range(0, 1) ? 8'hFF : 8'h00};
                else
                    rgb = COLOR_W'($urandom);
                item = make_item(($urandom_range(0, 4) == 0) ? CMD_PALETTE_WRITE : CMD_PIXEL,
                                 6'($urandom), rgb, $urandom_range(0, 9) == 0);
                push_item(item);
            end
            settle();
        end

        if (mismatch_count == 0 && pixels_due == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/npcm_pkg.sv
rtl/npcm_cell.sv
rtl/npcm_accum.sv
rtl/nearest_palette_color_mapper_unit.sv
rtl/npcm_checker.sv
tb/palette_map_checker.sv
tb/nearest_palette_color_mapper_unit_test.sv
